// File: sv/bds2_pkg.sv
package bds2_pkg;

   localparam int MAX_SRC_WIDTH = 4096;
   localparam int MAX_SRC_HEIGHT = 4096;
   localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
   localparam int SLOT_W = $clog2(LINE_DEPTH);

   localparam int CHAN_W = 16;
   localparam int PAIR_W = CHAN_W + 1;
   localparam int QUAD_W = CHAN_W + 2;
   localparam int BYTE_W = 8;
   localparam int DIM_W = 13;
   localparam int CNT_W = 12;
   localparam int LINE_W = 3 * PAIR_W;
   localparam int SCALE_SHIFT = 17;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type REG_SRC_WIDTH = 1'b0;
   localparam csr_index_type REG_SRC_HEIGHT = 1'b1;

   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_sum_type;

endpackage

// File: sv/box_downsample_2x2_rgb.sv
// Halves an RGB pixel stream in both directions with a 2x2 box filter. Pixels
// enter in raster order, one word per cycle unless stalled, and each output byte
// is (sum of four samples * 255) >> 17, saturated at 255. After its bottom-right
// source pixel is accepted, an output word is held in s1, then in the output
// registers; rsp_frame_last marks the final word of a frame. Sums of the even
// row's pixel pairs sit in a line memory of 2048 entries with one write and one
// read port, so it sustains one pixel per cycle unless output stalls. Width
// and height writes take effect at once and should be made between frames.
module box_downsample_2x2_rgb (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bds2_pkg::CHAN_W-1:0]     req_red_in,
   input  logic [bds2_pkg::CHAN_W-1:0]     req_green_in,
   input  logic [bds2_pkg::CHAN_W-1:0]     req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bds2_pkg::BYTE_W-1:0]     rsp_red_out,
   output logic [bds2_pkg::BYTE_W-1:0]     rsp_green_out,
   output logic [bds2_pkg::BYTE_W-1:0]     rsp_blue_out,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  bds2_pkg::csr_index_type         csr_index,
   input  logic [bds2_pkg::DIM_W-1:0]      csr_data
);
   import bds2_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [3*CHAN_W-1:0] left_ff, left_in;

   logic s1_valid_ff, s1_valid_in;
   pair_sum_type s1_pair_ff, s1_pair_in;
   logic s1_last_ff, s1_last_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic last_ff, last_in;

   logic [DIM_W-1:0] w_eff, h_eff, even_w, even_h;
   logic accept, out_free, emit, line_wr;
   logic [SLOT_W-1:0] slot;
   pair_sum_type pair_now, line_rd;
   logic [LINE_W-1:0] line_rd_bits;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(2)) begin
         r = DIM_W'(2);
      end else if (int'(v) > hi) begin
         r = DIM_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] scale_byte(input logic [QUAD_W-1:0] sum);
      logic [QUAD_W+BYTE_W-1:0] prod;
      logic [QUAD_W+BYTE_W-SCALE_SHIFT-1:0] v;
      prod = {sum, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, sum};
      v = prod[QUAD_W+BYTE_W-1:SCALE_SHIFT];
      if (v > (QUAD_W+BYTE_W-SCALE_SHIFT)'(255)) begin
         return {BYTE_W{1'b1}};
      end
      return v[BYTE_W-1:0];
   endfunction

   assign w_eff = clamp_dim(width_ff, MAX_SRC_WIDTH);
   assign h_eff = clamp_dim(height_ff, MAX_SRC_HEIGHT);
   assign even_w = {w_eff[DIM_W-1:1], 1'b0};
   assign even_h = {h_eff[DIM_W-1:1], 1'b0};

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign slot = col_ff[SLOT_W:1];
   assign pair_now.red = {1'b0, left_ff[3*CHAN_W-1:2*CHAN_W]} + {1'b0, req_red_in};
   assign pair_now.green = {1'b0, left_ff[2*CHAN_W-1:CHAN_W]} + {1'b0, req_green_in};
   assign pair_now.blue = {1'b0, left_ff[CHAN_W-1:0]} + {1'b0, req_blue_in};

   assign line_wr = accept && col_ff[0] && !row_ff[0];
   assign emit = accept && col_ff[0] && row_ff[0]
                 && ({1'b0, col_ff} < even_w) && ({1'b0, row_ff} < even_h);

   bds2_ram #(
      .WIDTH(LINE_W),
      .DEPTH(LINE_DEPTH)
   ) u_line (
      .clock  (clock),
      .wr_en  (line_wr),
      .wr_addr(slot),
      .wr_data(pair_now),
      .rd_en  (emit),
      .rd_addr(slot),
      .rd_data(line_rd_bits)
   );
   assign line_rd = pair_sum_type'(line_rd_bits);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      left_in = left_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            left_in = {req_red_in, req_green_in, req_blue_in};
         end
         if ({1'b0, col_ff} >= w_eff - DIM_W'(1)) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} >= h_eff - DIM_W'(1)) ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_pair_in = s1_pair_ff;
      s1_last_in = s1_last_ff;
      if (req_ready) begin
         s1_valid_in = emit;
         s1_pair_in = pair_now;
         s1_last_in = ({1'b0, col_ff} == even_w - DIM_W'(1))
                      && ({1'b0, row_ff} == even_h - DIM_W'(1));
      end

      rsp_valid_in = rsp_valid_ff;
      red_in = red_ff;
      green_in = green_ff;
      blue_in = blue_ff;
      last_in = last_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         red_in = scale_byte({1'b0, line_rd.red} + {1'b0, s1_pair_ff.red});
         green_in = scale_byte({1'b0, line_rd.green} + {1'b0, s1_pair_ff.green});
         blue_in = scale_byte({1'b0, line_rd.blue} + {1'b0, s1_pair_ff.blue});
         last_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SRC_WIDTH: width_ff <= csr_data;
               REG_SRC_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         left_ff <= left_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_pair_ff <= s1_pair_in;
      s1_last_ff <= s1_last_in;
      red_ff <= red_in;
      green_ff <= green_in;
      blue_ff <= blue_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_out = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out = blue_ff;
   assign rsp_frame_last = last_ff;

endmodule

// File: sv/bds2_ram.sv
module bds2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/box_downsample_2x2_rgb_tb.sv
`timescale 1ns / 100ps

module box_downsample_2x2_rgb_tb;
   import bds2_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_GAP = 6;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 24;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_PHASES = 7;
   localparam int RUN_LIMIT_NS = 20_000_000;
   localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
   localparam logic [CHAN_W-1:0] FULL_SCALE = 16'd32768;

   typedef struct {
      logic [CHAN_W-1:0] red, green, blue;
      int gap;
   } src_word_type;

   typedef struct {
      logic [BYTE_W-1:0] red, green, blue;
      logic last;
   } out_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_red_out;
   logic [BYTE_W-1:0] rsp_green_out;
   logic [BYTE_W-1:0] rsp_blue_out;
   logic rsp_frame_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = REG_SRC_WIDTH;
   logic [DIM_W-1:0] csr_data = '0;

   src_word_type pending_pixels[$];
   out_word_type expected_pixels[$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int gap_count = 0;
   int stall_count = 0;
   int hold_cycles = 0;
   int hold_requests = 0;
   int holds_served = 0;
   bit sender_smooth = 1'b0;
   bit rsp_calm = 1'b0;

   int mismatch_count = 0;
   int pixels_accepted = 0;
   int outputs_checked = 0;
   int reg_writes = 0;
   int size_settings = 0;

   logic [DIM_W-1:0] model_width = 13'd640;
   logic [DIM_W-1:0] model_height = 13'd480;
   pair_sum_type pair_line [LINE_DEPTH];
   logic [CHAN_W-1:0] left_red = '0, left_green = '0, left_blue = '0;
   logic [CNT_W-1:0] col_count = '0, row_count = '0;

   box_downsample_2x2_rgb dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int effective_dim(logic [DIM_W-1:0] value, int limit);
      if (value < 2) return 2;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   function automatic logic [BYTE_W-1:0] scale_to_byte(logic [QUAD_W-1:0] sum);
      logic [QUAD_W+BYTE_W-1:0] scaled;
      scaled = {{BYTE_W{1'b0}}, sum};
      scaled = (QUAD_W+BYTE_W)'(scaled * 255);
      scaled = scaled >> SCALE_SHIFT;
      return (scaled > 255) ? 8'hFF : scaled[BYTE_W-1:0];
   endfunction

   task automatic advance_raster(inout int col, inout int row, input int w, input int h);
      if (col >= w - 1) begin
         col = 0;
         row = (row >= h - 1) ? 0 : (row + 1) % (1 << CNT_W);
      end else begin
         col = (col + 1) % (1 << CNT_W);
      end
   endtask

   task automatic downsample_pixel(input logic [CHAN_W-1:0] red, green, blue);
      int w, h, even_w, even_h, col, row;
      logic [SLOT_W-1:0] slot;
      logic [QUAD_W-1:0] red_sum, green_sum, blue_sum;
      out_word_type word;
      w = effective_dim(model_width, MAX_SRC_WIDTH);
      h = effective_dim(model_height, MAX_SRC_HEIGHT);
      even_w = w & ~1;
      even_h = h & ~1;
      col = col_count;
      row = row_count;
      slot = SLOT_W'(col >> 1);
      if (col % 2 == 0) begin
         left_red = red;
         left_green = green;
         left_blue = blue;
      end else if (row % 2 == 0) begin
         pair_line[slot].red = left_red + red;
         pair_line[slot].green = left_green + green;
         pair_line[slot].blue = left_blue + blue;
      end else if (col < even_w && row < even_h) begin
         red_sum = pair_line[slot].red + left_red + red;
         green_sum = pair_line[slot].green + left_green + green;
         blue_sum = pair_line[slot].blue + left_blue + blue;
         word.red = scale_to_byte(red_sum);
         word.green = scale_to_byte(green_sum);
         word.blue = scale_to_byte(blue_sum);
         word.last = (col == even_w - 1 && row == even_h - 1);
         expected_pixels.push_back(word);
      end
      advance_raster(col, row, w, h);
      col_count = CNT_W'(col);
      row_count = CNT_W'(row);
   endtask

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FULL_SCALE;
         2: return '1;
         3, 4: return CHAN_W'($urandom);
         default: return CHAN_W'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic queue_word(input logic [CHAN_W-1:0] red, green, blue);
      src_word_type word;
      word.red = red;
      word.green = green;
      word.blue = blue;
      word.gap = sender_smooth ? 0 : $urandom_range(0, MAX_GAP);
      pending_pixels.push_back(word);
   endtask

   task automatic queue_pixels(input int count);
      repeat (count) queue_word(random_channel(), random_channel(), random_channel());
   endtask

   task automatic queue_frames(input int frames);
      queue_pixels(frames * effective_dim(model_width, MAX_SRC_WIDTH)
                   * effective_dim(model_height, MAX_SRC_HEIGHT));
   endtask

   task automatic queue_to_frame_end();
      int col, row, w, h, count;
      col = col_count;
      row = row_count;
      w = effective_dim(model_width, MAX_SRC_WIDTH);
      h = effective_dim(model_height, MAX_SRC_HEIGHT);
      count = 0;
      do begin
         advance_raster(col, row, w, h);
         count++;
      end while (col != 0 || row != 0);
      queue_pixels(count);
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= DIM_W'(value);
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input int w, input int h);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      size_settings++;
   endtask

   task automatic pick_pace();
      sender_smooth = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_count <= 0;
      end else if (!req_valid || req_taken) begin
         if (pending_pixels.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_count < pending_pixels[0].gap) begin
            req_valid <= 1'b0;
            gap_count <= gap_count + 1;
         end else begin
            req_red_in <= pending_pixels[0].red;
            req_green_in <= pending_pixels[0].green;
            req_blue_in <= pending_pixels[0].blue;
            req_valid <= 1'b1;
            gap_count <= 0;
            pending_pixels.delete(0);
         end
      end
   end

   always @(negedge clock) begin : receiver
      int stall_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_count <= 0;
         hold_cycles <= 0;
      end else if (hold_requests != holds_served) begin
         rsp_ready <= 1'b0;
         if (hold_cycles >= LONG_HOLD - 1) begin
            holds_served <= holds_served + 1;
            hold_cycles <= 0;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end else if (rsp_taken && !rsp_calm) begin
         stall_draw = $urandom_range(0, MAX_GAP);
         rsp_ready <= (stall_draw == 0);
         stall_count <= (stall_draw > 0) ? stall_draw - 1 : 0;
      end else if (stall_count > 0) begin
         rsp_ready <= 1'b0;
         stall_count <= stall_count - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : output_check
      out_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SRC_WIDTH) begin
               model_width = csr_data;
            end else begin
               model_height = csr_data;
            end
            reg_writes++;
         end
         if (req_valid && req_ready) begin
            downsample_pixel(req_red_in, req_green_in, req_blue_in);
            pixels_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            outputs_checked++;
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Word %0d arrived with none pending: r %0d g %0d b %0d last %0b",
                           outputs_checked, rsp_red_out, rsp_green_out, rsp_blue_out,
                           rsp_frame_last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red_out !== want.red || rsp_green_out !== want.green ||
                   rsp_blue_out !== want.blue || rsp_frame_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("Word %0d: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                              outputs_checked, want.red, want.green, want.blue, want.last,
                              rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_last);
               end
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames of the smallest size: zero, full scale, saturation and bit patterns.
      set_size(2, 2);
      repeat (4) queue_word('0, '0, '0);
      repeat (4) queue_word(FULL_SCALE, FULL_SCALE, FULL_SCALE);
      repeat (4) queue_word('1, '1, '1);
      queue_word(16'd1, 16'd16384, 16'd32767);
      repeat (3) queue_word('0, 16'd16384, 16'd32767);
      repeat (2) begin
         queue_word(16'hAAAA, 16'h5555, 16'h8000);
         queue_word(16'h5555, 16'hAAAA, 16'h7FFF);
      end
      queue_word(FULL_SCALE, 16'd0, 16'hFFFF);
      queue_word(16'd32767, 16'd1, 16'd0);
      queue_word(FULL_SCALE, FULL_SCALE, 16'd1);
      queue_word(FULL_SCALE, 16'd0, 16'hFFFE);
      wait_idle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_pace();
         if (phase == 4) begin
            set_size($urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            set_size($urandom_range(2, 13), $urandom_range(2, 9));
         end
         queue_frames($urandom_range(1, 2));
         wait_idle();
      end

      // The output side stalls for a long stretch while input words keep coming.
      sender_smooth = 1'b1;
      rsp_calm = 1'b0;
      set_size(16, 8);
      hold_requests++;
      queue_frames(1);
      wait_idle();

      // Size changes in the middle of a frame, only ever narrowing the line.
      pick_pace();
      queue_pixels(16 * 3 + 5);
      wait_idle();
      set_size(10, 5);
      queue_to_frame_end();
      wait_idle();
      set_size(16, 8);
      queue_pixels(16 * 5 + 12);
      wait_idle();
      set_size(8, 4);
      queue_to_frame_end();
      wait_idle();

      // The largest sizes, each cut short by narrowing the frame part way through.
      pick_pace();
      set_size(DIM_MAX_CODE, 0);
      queue_pixels(21);
      wait_idle();
      set_size(20, 2);
      queue_to_frame_end();
      wait_idle();
      pick_pace();
      set_size(1, DIM_MAX_CODE);
      queue_pixels(2 * 21);
      wait_idle();
      set_size(2, 22);
      queue_to_frame_end();
      wait_idle();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d source pixels and %0d output words over %0d image sizes,",
               pixels_accepted, outputs_checked, size_settings);
      $display("%0d register writes, clamped sizes, mid-frame size changes and a long stall.",
               reg_writes);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/bds2_pkg.sv
sv/bds2_ram.sv
sv/box_downsample_2x2_rgb.sv
tb/sv/box_downsample_2x2_rgb_tb.sv
